/* sv/first_match_stream_editor_unit_assert.svh */
// Assertion macros shared by the stream editor modules.
`ifndef FIRST_MATCH_STREAM_EDITOR_UNIT_ASSERT_SVH
`define FIRST_MATCH_STREAM_EDITOR_UNIT_ASSERT_SVH

// Check a condition at every clock edge outside reset.
`define FMSE_ASSERT(label, clk_s, rstn_s, expr) \
	label: assert property (@(posedge clk_s) disable iff (!rstn_s) (expr)) \
		else $error("stream editor check failed");

// Check that a condition in one cycle leads to another in the next.
`define FMSE_ASSERT_NEXT(label, clk_s, rstn_s, ante, cons) \
	label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
		else $error("stream editor sequence check failed");

`endif

/* sv/fmse_pkg.sv */
// Types and constants of the first-match stream editor.
package fmse_pkg;

	localparam int PATTERN_MAX = 8;
	localparam int REPLACE_MAX = 8;
	localparam int WIN_DEPTH   = PATTERN_MAX - 1;
	localparam int CHAR_W      = 8;
	localparam int POS_W       = 3;
	localparam int LEN_W       = 4;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = 3;

	typedef enum logic [1:0] {
		MODE_COPY      = 2'd0,
		MODE_REPLACE   = 2'd1,
		MODE_ERASE     = 2'd2,
		MODE_DUPLICATE = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		CFG_EDIT_MODE       = 3'd0,
		CFG_PATTERN_TEXT    = 3'd1,
		CFG_PATTERN_LENGTH  = 3'd2,
		CFG_REPLACE_TEXT    = 3'd3,
		CFG_REPLACE_LENGTH  = 3'd4
	} cfg_idx_t;

	// One emit job: a run of window characters, then an optional second run
	// taken from the replacement text or again from the window.
	typedef struct packed {
		logic [PATTERN_MAX-1:0][CHAR_W-1:0] chars;
		logic [LEN_W-1:0]                   len1;
		logic                               rep_src;
		logic [POS_W-1:0]                   off;
		logic [LEN_W-1:0]                   len2;
		logic                               eos;
	} cmd_t;

	// Queue status seen by both sides.
	typedef struct packed {
		logic full;
		logic valid;
	} qstat_t;

endpackage

/* sv/fmse_front.sv */
// Front end: holds the character window, finds the first match, builds emit jobs.
`include "first_match_stream_editor_unit_assert.svh"

module fmse_front (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [fmse_pkg::CHAR_W-1:0]          in_char,
	input  logic                                 in_eos,
	input  fmse_pkg::mode_t                      mode,
	input  logic [fmse_pkg::PATTERN_MAX*8-1:0]   pattern_text,
	input  logic [fmse_pkg::LEN_W-1:0]           pattern_length,
	input  logic [fmse_pkg::LEN_W-1:0]           replacement_length,
	input  fmse_pkg::qstat_t                     qstat,
	output logic                                 q_push,
	output fmse_pkg::cmd_t                       q_cmd
);

	logic [fmse_pkg::CHAR_W-1:0] win_q [fmse_pkg::WIN_DEPTH];
	logic [fmse_pkg::POS_W-1:0]  fill_q;
	logic                        done_q;

	logic [fmse_pkg::PATTERN_MAX-1:0][fmse_pkg::CHAR_W-1:0] cur;
	logic [fmse_pkg::PATTERN_MAX-1:0][fmse_pkg::CHAR_W-1:0] shifted;
	logic [fmse_pkg::LEN_W-1:0] plen, rlen, tot, start, keep, drop, len1, len2;
	logic [fmse_pkg::POS_W-1:0] cidx;
	logic [fmse_pkg::POS_W-1:0] fill_d;
	logic                       done_d, hit, mismatch, accept, use_shift;

	assign in_ready = !qstat.full;
	assign accept   = in_valid && in_ready;

	// Classify the incoming character against the window.
	always_comb begin
		if (pattern_length == '0) begin
			plen = fmse_pkg::LEN_W'(1);
		end else if (pattern_length > fmse_pkg::LEN_W'(fmse_pkg::PATTERN_MAX)) begin
			plen = fmse_pkg::LEN_W'(fmse_pkg::PATTERN_MAX);
		end else begin
			plen = pattern_length;
		end
		if (replacement_length > fmse_pkg::LEN_W'(fmse_pkg::REPLACE_MAX)) begin
			rlen = fmse_pkg::LEN_W'(fmse_pkg::REPLACE_MAX);
		end else begin
			rlen = replacement_length;
		end

		// Held characters followed by the new one.
		cur = {fmse_pkg::PATTERN_MAX{in_char}};
		for (int i = 0; i < fmse_pkg::WIN_DEPTH; i++) begin
			if (fmse_pkg::POS_W'(i) < fill_q) begin
				cur[i] = win_q[i];
			end
		end
		tot   = {1'b0, fill_q} + fmse_pkg::LEN_W'(1);
		start = tot - plen;

		// Compare the newest plen characters with the pattern.
		mismatch = 1'b0;
		cidx     = '0;
		for (int j = 0; j < fmse_pkg::PATTERN_MAX; j++) begin
			cidx = fmse_pkg::POS_W'(start + fmse_pkg::LEN_W'(j));
			if (fmse_pkg::LEN_W'(j) < plen && cur[cidx] != pattern_text[8*j +: 8]) begin
				mismatch = 1'b1;
			end
		end
		hit = !done_q && (tot >= plen) && !mismatch;

		keep = done_q ? '0 : plen - fmse_pkg::LEN_W'(1);
		drop = tot - keep;
		for (int i = 0; i < fmse_pkg::PATTERN_MAX; i++) begin
			shifted[i] = cur[fmse_pkg::POS_W'(drop + fmse_pkg::LEN_W'(i))];
		end

		// Emit job and next window state.
		len1      = '0;
		len2      = '0;
		use_shift = 1'b0;
		fill_d    = fill_q;
		done_d    = done_q;
		if (hit) begin
			unique case (mode)
				fmse_pkg::MODE_REPLACE: begin
					len1 = start;
					len2 = rlen;
				end
				fmse_pkg::MODE_ERASE: begin
					len1 = start;
				end
				fmse_pkg::MODE_DUPLICATE: begin
					len1 = tot;
					len2 = plen;
				end
				default: begin
					len1 = tot;
				end
			endcase
			fill_d = '0;
			done_d = 1'b1;
		end else if (tot > keep) begin
			len1      = drop;
			use_shift = 1'b1;
			fill_d    = keep[fmse_pkg::POS_W-1:0];
		end else begin
			fill_d = tot[fmse_pkg::POS_W-1:0];
		end
		if (in_eos) begin
			if (!hit) begin
				len1 = tot;
			end
			fill_d = '0;
			done_d = 1'b0;
		end

		q_cmd.chars   = cur;
		q_cmd.len1    = len1;
		q_cmd.rep_src = (mode == fmse_pkg::MODE_REPLACE);
		q_cmd.off     = start[fmse_pkg::POS_W-1:0];
		q_cmd.len2    = len2;
		q_cmd.eos     = in_eos;
		q_push        = accept && (len1 != '0 || len2 != '0 || in_eos);
	end

	// Advance window control on every accepted beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			done_q <= 1'b0;
		end else if (accept) begin
			fill_q <= fill_d;
			done_q <= done_d;
		end
	end

	// Hold the characters that may still start a match.
	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < fmse_pkg::WIN_DEPTH; i++) begin
				win_q[i] <= use_shift ? shifted[i] : cur[i];
			end
		end
	end

	`FMSE_ASSERT_NEXT(a_eos_clears, clk, arst_n, accept && in_eos, fill_q == '0 && !done_q)
	`FMSE_ASSERT_NEXT(a_hit_marks_done, clk, arst_n, accept && hit && !in_eos, done_q && fill_q == '0)

endmodule

/* sv/fmse_queue.sv */
// Short job queue between the front end and the emitter.
`include "first_match_stream_editor_unit_assert.svh"

module fmse_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  fmse_pkg::cmd_t   cmd_in,
	input  logic             pop,
	output fmse_pkg::cmd_t   cmd_out,
	output fmse_pkg::qstat_t qstat
);

	fmse_pkg::cmd_t                entry_q [fmse_pkg::QUEUE_DEPTH];
	logic [fmse_pkg::QPTR_W-1:0]   wr_q, rd_q;
	logic [fmse_pkg::QCNT_W-1:0]   cnt_q;
	logic                          do_pop;

	assign qstat.full  = (cnt_q == fmse_pkg::QCNT_W'(fmse_pkg::QUEUE_DEPTH));
	assign qstat.valid = (cnt_q != '0);
	assign cmd_out     = entry_q[rd_q];
	assign do_pop      = pop && qstat.valid;

	// Advance pointers and occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + fmse_pkg::QPTR_W'(1);
			end
			if (do_pop) begin
				rd_q <= rd_q + fmse_pkg::QPTR_W'(1);
			end
			if (push && !do_pop) begin
				cnt_q <= cnt_q + fmse_pkg::QCNT_W'(1);
			end else if (do_pop && !push) begin
				cnt_q <= cnt_q - fmse_pkg::QCNT_W'(1);
			end
		end
	end

	// Store jobs.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q] <= cmd_in;
		end
	end

	`FMSE_ASSERT(a_no_overflow, clk, arst_n, !(push && qstat.full))

endmodule

/* sv/fmse_back.sv */
// Back end: walks one job per beat sequence into the output register.
`include "first_match_stream_editor_unit_assert.svh"

module fmse_back (
	input  logic                               clk,
	input  logic                               arst_n,
	input  fmse_pkg::cmd_t                     cmd,
	input  fmse_pkg::qstat_t                   qstat,
	output logic                               pop,
	input  logic [fmse_pkg::REPLACE_MAX*8-1:0] replacement_text,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [fmse_pkg::CHAR_W-1:0]        out_char,
	output logic                               out_present,
	output logic                               out_last
);

	logic [fmse_pkg::LEN_W-1:0]   idx_q, last_idx, sub;
	logic [fmse_pkg::LEN_W:0]     total;
	logic [fmse_pkg::CHAR_W-1:0]  beat_char;
	logic                         out_free, step, at_end;

	assign out_free = !out_valid || out_ready;
	assign step     = qstat.valid && out_free;

	// Select the character for the current position of the job.
	always_comb begin
		total    = {1'b0, cmd.len1} + {1'b0, cmd.len2};
		last_idx = (total == '0) ? '0 : fmse_pkg::LEN_W'(total - (fmse_pkg::LEN_W + 1)'(1));
		at_end   = (idx_q == last_idx);
		sub      = idx_q - cmd.len1;
		if (idx_q < cmd.len1) begin
			beat_char = cmd.chars[idx_q[fmse_pkg::POS_W-1:0]];
		end else if (cmd.rep_src) begin
			beat_char = replacement_text[{sub[fmse_pkg::POS_W-1:0], 3'b000} +: 8];
		end else begin
			beat_char = cmd.chars[cmd.off + sub[fmse_pkg::POS_W-1:0]];
		end
		pop = step && at_end;
	end

	// Advance the position within the job.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			if (step) begin
				idx_q <= at_end ? '0 : idx_q + fmse_pkg::LEN_W'(1);
			end
			if (out_free) begin
				out_valid <= qstat.valid;
			end
		end
	end

	// Load the output beat.
	always_ff @(posedge clk) begin
		if (step) begin
			out_char    <= (total == '0) ? '0 : beat_char;
			out_present <= (total != '0);
			out_last    <= cmd.eos && at_end;
		end
	end

	`FMSE_ASSERT(a_empty_is_last, clk, arst_n, !(out_valid && !out_present) || out_last)

endmodule

/* sv/first_match_stream_editor_unit.sv */
// Top level of the first-match stream editor: configuration, front, queue, back.
//
// Usage:
//   Input beats arrive on s_* (tdata = one character, tlast = end of string).
//   Edited characters leave on m_* (tdata = character, tuser = character
//   present, tlast = final beat of the string). A string whose end marker
//   has nothing to emit yields one beat with tuser low and tlast high.
//   The front end classifies each character in the cycle it is accepted and
//   queues an emit job; the back end sends one output beat per cycle while a
//   job is queued and m_tready is high. A job reaches m_* through the queue
//   entry and the output register. Characters that may start a match stay
//   in the window until matched, ruled out or the string ends. Throughput:
//   one input beat per cycle while each job has at most one output beat and
//   m_tready stays high; a longer job holds the back end until its last beat is
//   sent, and the four-entry queue absorbs short bursts before s_tready drops.
//   Reset clears the window, the queue and the output register; registers
//   return to copy mode, pattern length 1 and empty replacement.
//   When m_tready is low the output beat holds, the queue fills, and
//   s_tready falls once the queue is full.
//   Write cfg_* only while the block is idle.
module first_match_stream_editor_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,    // [7:0] char_in
	input  logic        s_tlast,    // end_of_string
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,    // [7:0] char_out
	output logic        m_tuser,    // [0] char_present
	output logic        m_tlast,    // last_out
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	fmse_pkg::mode_t  mode_q;
	logic [63:0]      pattern_text_q;
	logic [3:0]       pattern_length_q;
	logic [63:0]      replacement_text_q;
	logic [3:0]       replacement_length_q;

	fmse_pkg::cmd_t   push_cmd, head_cmd;
	fmse_pkg::qstat_t qstat;
	logic             push, pop;

	// Write configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q               <= fmse_pkg::MODE_COPY;
			pattern_text_q       <= '0;
			pattern_length_q     <= 4'd1;
			replacement_text_q   <= '0;
			replacement_length_q <= '0;
		end else if (cfg_we) begin
			unique case (fmse_pkg::cfg_idx_t'(cfg_index))
				fmse_pkg::CFG_EDIT_MODE:      mode_q <= fmse_pkg::mode_t'(cfg_data[1:0]);
				fmse_pkg::CFG_PATTERN_TEXT:   pattern_text_q <= cfg_data;
				fmse_pkg::CFG_PATTERN_LENGTH: pattern_length_q <= cfg_data[3:0];
				fmse_pkg::CFG_REPLACE_TEXT:   replacement_text_q <= cfg_data;
				fmse_pkg::CFG_REPLACE_LENGTH: replacement_length_q <= cfg_data[3:0];
				default: begin
				end
			endcase
		end
	end

	fmse_front u_front (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (s_tvalid),
		.in_ready           (s_tready),
		.in_char            (s_tdata),
		.in_eos             (s_tlast),
		.mode               (mode_q),
		.pattern_text       (pattern_text_q),
		.pattern_length     (pattern_length_q),
		.replacement_length (replacement_length_q),
		.qstat              (qstat),
		.q_push             (push),
		.q_cmd              (push_cmd)
	);

	fmse_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.cmd_in  (push_cmd),
		.pop     (pop),
		.cmd_out (head_cmd),
		.qstat   (qstat)
	);

	fmse_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (head_cmd),
		.qstat            (qstat),
		.pop              (pop),
		.replacement_text (replacement_text_q),
		.out_valid        (m_tvalid),
		.out_ready        (m_tready),
		.out_char         (m_tdata),
		.out_present      (m_tuser),
		.out_last         (m_tlast)
	);

endmodule

/* tb/first_match_stream_editor_unit_tb.sv */
// Self-checking stream testbench for the first-match stream editor.
`timescale 1ns / 1ps

module first_match_stream_editor_unit_tb;

	typedef struct packed {
		logic [7:0] ch;
		logic       eos;
	} in_beat_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       present;
		logic       last;
	} out_beat_t;

	localparam logic [7:0]  CH_R     = "R";
	localparam logic [7:0]  CH_E     = "E";
	localparam logic [7:0]  CH_D     = "D";
	localparam logic [63:0] RED_TEXT = {40'd0, CH_D, CH_E, CH_R};

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata   = '0;    // [7:0] char_in
	logic        s_tlast   = 1'b0;  // end_of_string
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [7:0]  m_tdata;           // [7:0] char_out
	logic        m_tuser;           // [0] char_present
	logic        m_tlast;           // last_out
	logic        cfg_we    = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [63:0] cfg_data  = '0;

	// register shadows, reset values
	fmse_pkg::mode_t mode_q = fmse_pkg::MODE_COPY;
	logic [63:0] pat_q  = '0;
	logic [3:0]  plen_q = 4'd1;
	logic [63:0] rep_q  = '0;
	logic [3:0]  rlen_q = 4'd0;

	// editor state mirror
	logic [7:0]  held [0:fmse_pkg::PATTERN_MAX-1];
	int unsigned held_cnt  = 0;
	logic        edit_done = 1'b0;

	in_beat_t    pending[$];
	out_beat_t   want_beats[$];
	int unsigned sent_cnt      = 0;
	int unsigned took_cnt      = 0;
	int unsigned mismatch_cnt  = 0;
	int unsigned src_gap_pct   = 0;
	int unsigned snk_stall_pct = 0;

	first_match_stream_editor_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	// pattern length as the block uses it: zero counts as one, cap at the maximum
	function automatic int unsigned pat_len();
		if (plen_q == 0)
			return 1;
		if (plen_q > fmse_pkg::PATTERN_MAX)
			return fmse_pkg::PATTERN_MAX;
		return plen_q;
	endfunction

	// Advance the editor mirror by one character and queue the beats it releases.
	function automatic void edit_char(input logic [7:0] c, input logic eos);
		logic [7:0]  outc [0:16];
		int unsigned n, plen, rlen, tot, keep, start, drop, i, j, k;
		logic        hit;
		n = 0;
		start = 0;
		plen = pat_len();
		rlen = (rlen_q > fmse_pkg::REPLACE_MAX) ? fmse_pkg::REPLACE_MAX : rlen_q;
		held[held_cnt] = c;
		tot = held_cnt + 1;
		hit = 1'b0;
		// test only the newest plen characters
		if (!edit_done && tot >= plen) begin
			start = tot - plen;
			hit = 1'b1;
			for (j = 0; j < plen; j++)
				if (held[start + j] != pat_q[8*j +: 8])
					hit = 1'b0;
		end
		if (hit) begin
			for (i = 0; i < start; i++) begin
				outc[n] = held[i];
				n++;
			end
			case (mode_q)
				fmse_pkg::MODE_REPLACE: begin
					for (j = 0; j < rlen; j++) begin
						outc[n] = rep_q[8*j +: 8];
						n++;
					end
				end
				fmse_pkg::MODE_ERASE: begin
					// drop the match
				end
				fmse_pkg::MODE_DUPLICATE: begin
					for (k = 0; k < 2; k++)
						for (j = 0; j < plen; j++) begin
							outc[n] = held[start + j];
							n++;
						end
				end
				default: begin
					for (j = 0; j < plen; j++) begin
						outc[n] = held[start + j];
						n++;
					end
				end
			endcase
			edit_done = 1'b1;
			held_cnt = 0;
		end else begin
			// release what can no longer start a match, oldest first
			keep = edit_done ? 0 : plen - 1;
			if (tot > keep) begin
				drop = tot - keep;
				for (i = 0; i < drop; i++) begin
					outc[n] = held[i];
					n++;
				end
				for (i = 0; i < keep; i++)
					held[i] = held[i + drop];
				held_cnt = keep;
			end else begin
				held_cnt = tot;
			end
		end
		// flush the window at the end marker and start a fresh string
		if (eos) begin
			for (i = 0; i < held_cnt; i++) begin
				outc[n] = held[i];
				n++;
			end
			held_cnt = 0;
			edit_done = 1'b0;
		end
		if (eos && n == 0)
			want_beats.push_back('{8'h00, 1'b0, 1'b1});
		for (i = 0; i < n; i++)
			want_beats.push_back('{outc[i], 1'b1, eos && (i == n - 1)});
	endfunction

	// pick a near-miss character half of the time
	function automatic logic [7:0] noise_char(input int unsigned plen);
		int unsigned pos;
		pos = $urandom_range(plen - 1);
		if ($urandom_range(1))
			return pat_q[8*pos +: 8];
		return 8'($urandom);
	endfunction

	task automatic write_reg(input fmse_pkg::cfg_idx_t idx, input logic [63:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			fmse_pkg::CFG_EDIT_MODE:      mode_q = fmse_pkg::mode_t'(val[1:0]);
			fmse_pkg::CFG_PATTERN_TEXT:   pat_q = val;
			fmse_pkg::CFG_PATTERN_LENGTH: plen_q = val[3:0];
			fmse_pkg::CFG_REPLACE_TEXT:   rep_q = val;
			fmse_pkg::CFG_REPLACE_LENGTH: rlen_q = val[3:0];
			default: begin
			end
		endcase
	endtask

	task automatic send_bytes(input logic [63:0] txt, input int unsigned cnt, input logic close);
		int unsigned i;
		for (i = 0; i < cnt; i++) begin
			pending.push_back('{txt[8*i +: 8], close && (i == cnt - 1)});
			sent_cnt++;
		end
	endtask

	// Wait until every queued beat is taken and every expected beat has left.
	task automatic settle();
		while (took_cnt != sent_cnt || want_beats.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Drive input beats from the pending queue; predict on each accepted beat.
	always @(posedge clk or negedge arst_n) begin : drive
		in_beat_t nxt;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tlast <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				edit_char(s_tdata, s_tlast);
				took_cnt++;
			end
			if (!s_tvalid || s_tready) begin
				if (pending.size() != 0 && $urandom_range(99) >= src_gap_pct) begin
					nxt = pending.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= nxt.ch;
					s_tlast <= nxt.eos;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Stall the output side at random.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else
			m_tready <= ($urandom_range(99) >= snk_stall_pct);
	end

	// Compare each output beat with the oldest expected one.
	always @(posedge clk) begin : check
		out_beat_t w;
		if (arst_n && m_tvalid && m_tready) begin
			if (want_beats.size() == 0) begin
				$error("unexpected beat: char_out %02h char_present %0d last_out %0d",
					m_tdata, m_tuser, m_tlast);
				mismatch_cnt++;
			end else begin
				w = want_beats.pop_front();
				if (m_tdata !== w.ch) begin
					$error("char_out: expected %02h, got %02h", w.ch, m_tdata);
					mismatch_cnt++;
				end
				if (m_tuser !== w.present) begin
					$error("char_present: expected %0d, got %0d", w.present, m_tuser);
					mismatch_cnt++;
				end
				if (m_tlast !== w.last) begin
					$error("last_out: expected %0d, got %0d", w.last, m_tlast);
					mismatch_cnt++;
				end
			end
		end
	end

	initial begin : stimulus
		int unsigned ph, profile, added, plen_now, r, reps, take, i, k;
		logic [7:0]  txt[$];
		logic [63:0] word;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: copy mode, one-character pattern of zero
		send_bytes(64'h00, 1, 1'b1);
		settle();

		// replace the first RED only; replacement length saturates to eight
		write_reg(fmse_pkg::CFG_EDIT_MODE, 64'(fmse_pkg::MODE_REPLACE));
		write_reg(fmse_pkg::CFG_PATTERN_TEXT, RED_TEXT);
		write_reg(fmse_pkg::CFG_PATTERN_LENGTH, 64'd3);
		write_reg(fmse_pkg::CFG_REPLACE_TEXT, 64'hFEDC_BA98_7654_3210);
		write_reg(fmse_pkg::CFG_REPLACE_LENGTH, 64'd15);
		send_bytes(64'h78, 1, 1'b0);
		send_bytes(RED_TEXT, 3, 1'b0);
		send_bytes(RED_TEXT, 3, 1'b1);
		settle();

		// erase a whole string: empty end beat
		write_reg(fmse_pkg::CFG_EDIT_MODE, 64'(fmse_pkg::MODE_ERASE));
		send_bytes(RED_TEXT, 3, 1'b1);
		settle();

		// duplicate a full-length pattern: sixteen beats from one input
		write_reg(fmse_pkg::CFG_EDIT_MODE, 64'(fmse_pkg::MODE_DUPLICATE));
		write_reg(fmse_pkg::CFG_PATTERN_TEXT, '1);
		write_reg(fmse_pkg::CFG_PATTERN_LENGTH, 64'd8);
		send_bytes('1, 8, 1'b1);
		settle();

		// shrink the pattern while characters wait in the window
		write_reg(fmse_pkg::CFG_EDIT_MODE, 64'(fmse_pkg::MODE_COPY));
		write_reg(fmse_pkg::CFG_PATTERN_TEXT, {32'd0, CH_D, RED_TEXT[23:0]});
		write_reg(fmse_pkg::CFG_PATTERN_LENGTH, 64'd4);
		send_bytes(RED_TEXT, 3, 1'b0);
		settle();
		write_reg(fmse_pkg::CFG_PATTERN_LENGTH, 64'd1);
		send_bytes(64'(CH_R), 1, 1'b1);
		settle();

		// random phases: new settings and idle profile each time
		for (ph = 0; ph < 8; ph++) begin
			settle();
			profile = (ph + ph / 4) % 4;
			word = {$urandom, $urandom};
			word[1:0] = 2'(ph % 4);
			write_reg(fmse_pkg::CFG_EDIT_MODE, word);

			word = {$urandom, $urandom};
			r = $urandom_range(7);
			word[3:0] = (r == 0) ? 4'd0 : (r == 1) ? 4'd15 : (r == 2) ? 4'd1 :
				(r == 3) ? 4'd8 : 4'($urandom_range(2, 7));
			write_reg(fmse_pkg::CFG_PATTERN_LENGTH, word);

			// small alphabet half of the time so the pattern overlaps itself
			word = {$urandom, $urandom};
			if ($urandom_range(1))
				for (k = 0; k < 8; k++)
					case ($urandom_range(2))
						0: word[8*k +: 8] = CH_R;
						1: word[8*k +: 8] = CH_E;
						default: word[8*k +: 8] = CH_D;
					endcase
			write_reg(fmse_pkg::CFG_PATTERN_TEXT, word);

			write_reg(fmse_pkg::CFG_REPLACE_TEXT, {$urandom, $urandom});
			word = {$urandom, $urandom};
			r = $urandom_range(5);
			word[3:0] = (r == 0) ? 4'd0 : (r == 1) ? 4'd8 : (r == 2) ? 4'd15 :
				4'($urandom_range(1, 7));
			write_reg(fmse_pkg::CFG_REPLACE_LENGTH, word);

			@(negedge clk);
			src_gap_pct = (profile == 1) ? 46 : (profile == 3) ? 32 : 0;
			snk_stall_pct = (profile == 2) ? 46 : (profile == 3) ? 32 : 0;

			plen_now = pat_len();
			added = 0;
			while (added < 24) begin
				txt.delete();
				r = $urandom_range(9);
				if (r < 8) begin
					// noise, the pattern once or twice (partly on a near miss), noise
					repeat ($urandom_range(3)) txt.push_back(noise_char(plen_now));
					reps = $urandom_range(1, 2);
					repeat (reps) begin
						take = (r == 7) ? $urandom_range(1, plen_now) : plen_now;
						for (i = 0; i < take; i++)
							txt.push_back(pat_q[8*i +: 8]);
					end
					repeat ($urandom_range(3)) txt.push_back(noise_char(plen_now));
				end else begin
					repeat ($urandom_range(1, 10)) txt.push_back(noise_char(plen_now));
				end
				for (i = 0; i < txt.size(); i++) begin
					pending.push_back('{txt[i], i == txt.size() - 1});
					sent_cnt++;
				end
				added += txt.size();
			end
		end

		settle();
		if (mismatch_cnt == 0 && want_beats.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

/* filelist.f */
+incdir+sv
sv/fmse_pkg.sv
sv/fmse_front.sv
sv/fmse_queue.sv
sv/fmse_back.sv
sv/first_match_stream_editor_unit.sv
tb/first_match_stream_editor_unit_tb.sv
